[src/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
package mcr_pkg;

    // Input operation codes, carried on s_tuser.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Configuration register word indexes (byte address 4*index).
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    localparam int MAX_RADIUS = 2047;

    localparam int COORD_W  = 11;
    localparam int CENTER_W = 12;
    localparam int PIXEL_W  = 14;
    localparam int COLOR_W  = 24;
    localparam int DEC_W    = 14;
    localparam int DE_W     = 13;
    localparam int DSE_W    = 14;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    // One step's worth of symmetric points, handed from the step unit to the emitter.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               done;
    } grp_t;

endpackage

[src/midpoint_circle_rasterizer.sv]
// Top level of the midpoint circle rasterizer: APB registers, step unit and point emitter.
//
//  Channel  Direction  Payload
//  s_       in         tdata: radius, color; tuser: operation (0 start, 1 advance)
//  m_       out        tdata: pixel_x, pixel_y, pixel_color; tlast: last_of_group;
//                      tuser: circle_done
//  APB      in/out     center_x at 0x0, center_y at 0x4
//
// Each start or advance transaction yields eight output transactions, one per cycle while
// m_tready is high; a new item is taken when the group buffer is empty or sends its last point.
// An advance with no circle running is absorbed with no output.
// The step state and the group buffer load at the accepting edge; the first point is then
// registered at the output once it is free. Reset is synchronous and clears control state.
// A stalled m_tready holds the point and, once the group buffer is full, s_tready.
module midpoint_circle_rasterizer
    import mcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [10:0] radius, [34:11] color, [39:35] zero
    input  logic                s_tuser,  // [0] operation
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // [13:0] pixel_x, [27:14] pixel_y,
                                          // [51:28] pixel_color, [55:52] zero
    output logic                m_tlast,  // last_of_group
    output logic                m_tuser   // [0] circle_done
);

    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic                cfg_write;
    logic                s_accept;
    logic                step_emit;
    logic                step_active;
    grp_t                grp_next;
    logic                grp_ready;
    logic [PIXEL_W-1:0]  out_x, out_y;
    logic [COLOR_W-1:0]  out_color;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_CENTER_X: center_x_reg <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[CENTER_W-1:0];
            endcase
        end
    end

    // Misaligned reads return zero.
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_CENTER_X: prdata = {{(32-CENTER_W){1'b0}}, center_x_reg};
                REG_CENTER_Y: prdata = {{(32-CENTER_W){1'b0}}, center_y_reg};
            endcase
        end
    end

    assign s_tready = grp_ready;
    assign s_accept = s_tvalid && s_tready;

    mcr_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (s_accept),
        .in_operation (s_tuser),
        .in_radius    (s_tdata[COORD_W-1:0]),
        .in_color     (s_tdata[COORD_W+COLOR_W-1:COORD_W]),
        .emit         (step_emit),
        .grp_next     (grp_next),
        .active       (step_active)
    );

    mcr_octant u_octant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_load  (s_accept && step_emit),
        .grp_in    (grp_next),
        .grp_ready (grp_ready),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_color (out_color),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

    assign m_tdata = {{(M_DATA_W-2*PIXEL_W-COLOR_W){1'b0}}, out_color, out_y, out_x};

    // A start leaves a circle running exactly when its radius is nonzero.
    a_start_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_START)
        |=> (step_active == ($past(s_tdata[COORD_W-1:0]) != '0)))
        else $error("circle activity does not follow start radius");

    // An advance with no circle running leaves the rasterizer stopped.
    a_idle_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_ADVANCE && !step_active) |=> !step_active)
        else $error("advance restarted a finished circle");

    // Before the last point of a group, circle_done stays the same from one point to the next.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || ($stable(m_tuser) || m_tlast)
            || $past(m_tlast)))
        else $error("circle_done changed inside a group");

endmodule

[src/mcr_step.sv]
// Midpoint step unit: holds the circle state and computes its next value.
module mcr_step
    import mcr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic               in_operation,
    input  logic [COORD_W-1:0] in_radius,
    input  logic [COLOR_W-1:0] in_color,
    output logic               emit,
    output grp_t               grp_next,
    output logic               active
);

    logic [COORD_W-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]      cur_y_reg, cur_y_next;
    logic signed [DEC_W-1:0] decision_reg, decision_next;
    logic [DE_W-1:0]         delta_e_reg, delta_e_next;
    logic signed [DSE_W-1:0] delta_se_reg, delta_se_next;
    logic [COLOR_W-1:0]      color_reg, color_next;
    logic                    active_reg, active_next;
    logic [COORD_W-1:0]      radius_sat;

    assign radius_sat = (in_radius > MAX_RADIUS) ? COORD_W'(MAX_RADIUS) : in_radius;

    always_comb begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        decision_next = decision_reg;
        delta_e_next  = delta_e_reg;
        delta_se_next = delta_se_reg;
        color_next    = color_reg;
        emit          = 1'b0;
        if (in_operation == OP_START) begin
            cur_x_next    = '0;
            cur_y_next    = radius_sat;
            decision_next = DEC_W'(1) - {{(DEC_W-COORD_W){1'b0}}, radius_sat};
            delta_e_next  = DE_W'(3);
            delta_se_next = DSE_W'(5) - {{(DSE_W-COORD_W-1){1'b0}}, radius_sat, 1'b0};
            color_next    = in_color;
            emit          = 1'b1;
        end else if (active_reg) begin
            if (decision_reg[DEC_W-1]) begin
                decision_next = decision_reg + {{(DEC_W-DE_W){1'b0}}, delta_e_reg};
                delta_se_next = delta_se_reg + DSE_W'(2);
            end else begin
                decision_next = decision_reg + delta_se_reg;
                delta_se_next = delta_se_reg + DSE_W'(4);
                cur_y_next    = cur_y_reg - COORD_W'(1);
            end
            delta_e_next = delta_e_reg + DE_W'(2);
            cur_x_next   = cur_x_reg + COORD_W'(1);
            emit         = 1'b1;
        end
        active_next = emit ? (cur_y_next > cur_x_next) : active_reg;
    end

    assign grp_next = '{x: cur_x_next, y: cur_y_next, color: color_next, done: !active_next};
    assign active   = active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            decision_reg <= '0;
            delta_e_reg  <= DE_W'(3);
            delta_se_reg <= DSE_W'(5);
            color_reg    <= '0;
            active_reg   <= 1'b0;
        end else if (in_accept) begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            decision_reg <= decision_next;
            delta_e_reg  <= delta_e_next;
            delta_se_reg <= delta_se_next;
            color_reg    <= color_next;
            active_reg   <= active_next;
        end
    end

endmodule

[src/mcr_octant.sv]
// Group buffer and point emitter: sends the eight symmetric points of one step.
module mcr_octant
    import mcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                grp_load,
    input  grp_t                grp_in,
    output logic                grp_ready,
    input  logic [CENTER_W-1:0] center_x,
    input  logic [CENTER_W-1:0] center_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PIXEL_W-1:0]  out_x,
    output logic [PIXEL_W-1:0]  out_y,
    output logic [COLOR_W-1:0]  out_color,
    output logic                out_last,
    output logic                out_done
);

    logic               grp_valid_reg;
    grp_t               grp_reg;
    logic [2:0]         idx_reg;
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_x_reg, out_x_next;
    logic [PIXEL_W-1:0] out_y_reg, out_y_next;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic               out_load;
    logic               point_adv;
    logic [PIXEL_W-1:0] px, py, nx, ny, dx, dy;
    logic [PIXEL_W-1:0] cx, cy;

    assign out_load  = !out_valid_reg || out_ready;
    assign point_adv = grp_valid_reg && out_load;
    assign grp_ready = !grp_valid_reg || (point_adv && idx_reg == 3'd7);

    assign px = {{(PIXEL_W-COORD_W){1'b0}}, grp_reg.x};
    assign py = {{(PIXEL_W-COORD_W){1'b0}}, grp_reg.y};
    assign nx = PIXEL_W'(0) - px;
    assign ny = PIXEL_W'(0) - py;
    assign cx = {{(PIXEL_W-CENTER_W){1'b0}}, center_x};
    assign cy = {{(PIXEL_W-CENTER_W){1'b0}}, center_y};

    // Octant order: (x,y) (y,x) (x,-y) (-y,x) (y,-x) (-x,-y) (-y,-x) (-x,y).
    always_comb begin
        unique case (idx_reg)
            3'd0: begin dx = px; dy = py; end
            3'd1: begin dx = py; dy = px; end
            3'd2: begin dx = px; dy = ny; end
            3'd3: begin dx = ny; dy = px; end
            3'd4: begin dx = py; dy = nx; end
            3'd5: begin dx = nx; dy = ny; end
            3'd6: begin dx = ny; dy = nx; end
            3'd7: begin dx = nx; dy = py; end
        endcase
        out_x_next = cx + dx;
        out_y_next = cy + dy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (grp_load) begin
                grp_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (point_adv) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    grp_valid_reg <= 1'b0;
                end
            end
            if (point_adv) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_load) begin
            grp_reg <= grp_in;
        end
        if (point_adv) begin
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_color_reg <= grp_reg.color;
            out_last_reg  <= (idx_reg == 3'd7);
            out_done_reg  <= grp_reg.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_color = out_color_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the midpoint circle rasterizer with directed and random circles.
module tb;
    import mcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;

    typedef struct packed {
        logic [PIXEL_W-1:0] x;
        logic [PIXEL_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               done;
    } pixel_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [2:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // [10:0] radius, [34:11] color, [39:35] zero
    logic                s_tuser  = OP_START;  // [0] operation
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;  // [13:0] pixel_x, [27:14] pixel_y, [51:28] pixel_color
    logic                m_tlast;
    logic                m_tuser;  // [0] circle_done

    // Predicted copy of the block's registers and step state.
    logic [CENTER_W-1:0]     model_center_x = '0;
    logic [CENTER_W-1:0]     model_center_y = '0;
    logic [COORD_W-1:0]      pen_x          = '0;
    logic [COORD_W-1:0]      pen_y          = '0;
    logic signed [DEC_W-1:0] decision       = '0;
    logic signed [DE_W-1:0]  delta_e        = DE_W'(3);
    logic signed [DSE_W-1:0] delta_se       = DSE_W'(5);
    logic [COLOR_W-1:0]      pen_color      = '0;
    logic                    circle_live    = 1'b0;

    pixel_t expected_pixels [$];

    int  failures         = 0;
    int  items_sent       = 0;
    int  groups_queued    = 0;
    int  circles_finished = 0;
    int  pixels_checked   = 0;
    int  idle_cycles      = 0;
    int  ready_hold       = 0;
    int  ready_pick;
    bit  flow_burst       = 1'b0;

    midpoint_circle_rasterizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly no pause, some short ones and a few long ones; none during a burst phase.
    function automatic int pick_pause();
        int r;
        if (flow_burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Pushes the eight symmetric points of the current position, in emission order.
    task automatic queue_group();
        int     ox [8];
        int     oy [8];
        int     px;
        int     py;
        pixel_t p;
        px = int'(pen_x);
        py = int'(pen_y);
        ox = '{px, py, px, -py, py, -px, -py, -px};
        oy = '{py, px, -py, px, -px, -py, -px, py};
        for (int k = 0; k < 8; k++) begin
            p.x     = PIXEL_W'(int'(model_center_x) + ox[k]);
            p.y     = PIXEL_W'(int'(model_center_y) + oy[k]);
            p.color = pen_color;
            p.last  = (k == 7);
            p.done  = !circle_live;
            expected_pixels.push_back(p);
        end
        groups_queued++;
        if (!circle_live) begin
            circles_finished++;
        end
    endtask

    task automatic rasterize_step(input logic op, input logic [COORD_W-1:0] radius,
                                  input logic [COLOR_W-1:0] color);
        int r;
        if (op == OP_START) begin
            r = (int'(radius) > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
            pen_color   = color;
            pen_x       = '0;
            pen_y       = COORD_W'(r);
            decision    = DEC_W'(1 - r);
            delta_e     = DE_W'(3);
            delta_se    = DSE_W'(5 - 2 * r);
            circle_live = pen_y > pen_x;
            queue_group();
        end else if (circle_live) begin
            if (decision < 0) begin
                decision = decision + delta_e;
                delta_e  = delta_e + DE_W'(2);
                delta_se = delta_se + DSE_W'(2);
            end else begin
                decision = decision + delta_se;
                delta_e  = delta_e + DE_W'(2);
                delta_se = delta_se + DSE_W'(4);
                pen_y    = pen_y - COORD_W'(1);
            end
            pen_x       = pen_x + COORD_W'(1);
            circle_live = pen_y > pen_x;
            queue_group();
        end
    endtask

    // Valid stays high from one item to the next when no pause is drawn.
    task automatic send_item(input logic op, input logic [COORD_W-1:0] radius,
                             input logic [COLOR_W-1:0] color);
        int gap;
        gap = pick_pause();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - COORD_W - COLOR_W){1'b0}}, color, radius};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        rasterize_step(op, radius, color);
    endtask

    // An advance with no circle running gives no pixel, so extra idle cycles follow the empty queue.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (index == REG_CENTER_X) begin
            model_center_x = value[CENTER_W-1:0];
        end else begin
            model_center_y = value[CENTER_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_center(input logic [31:0] cx, input logic [31:0] cy);
        apb_write(REG_CENTER_X, cx);
        apb_write(REG_CENTER_Y, cy);
    endtask

    task automatic test_advance_without_circle();
        send_item(OP_ADVANCE, 11'h7FF, 24'hFFFFFF);
        send_item(OP_ADVANCE, 11'h000, 24'h000000);
    endtask

    task automatic test_zero_radius();
        send_item(OP_START, 11'd0, 24'hFFFFFF);
        send_item(OP_ADVANCE, 11'd3, 24'h0F0F0F);
    endtask

    task automatic test_radius_one();
        send_item(OP_START, 11'd1, 24'h000000);
        send_item(OP_ADVANCE, 11'd0, 24'hFFFFFF);
        send_item(OP_ADVANCE, 11'd1, 24'h123456);
    endtask

    // Largest radius at both center extremes, plus a restart while a circle is running.
    task automatic test_center_extremes();
        wait_drained();
        set_center(32'hFFFF_FFFF, 32'h0000_0FFF);
        send_item(OP_START, 11'd2047, 24'h5A5A5A);
        repeat (3) send_item(OP_ADVANCE, 11'd0, 24'h000000);
        send_item(OP_START, 11'd5, 24'hA5A5A5);
        while (circle_live) send_item(OP_ADVANCE, 11'd0, 24'h000000);
        send_item(OP_ADVANCE, 11'd0, 24'h000000);
        wait_drained();
        set_center(32'hFFFF_F000, 32'h0000_0000);
        send_item(OP_START, 11'd2047, 24'h123456);
        repeat (2) send_item(OP_ADVANCE, 11'h7FF, 24'hFFFFFF);
    endtask

    task automatic draw_circle();
        logic [COORD_W-1:0] radius;
        int                 steps;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            radius = '0;
        end else if (pick < 75) begin
            radius = COORD_W'($urandom_range(1, 20));
        end else begin
            radius = COORD_W'($urandom_range(0, MAX_RADIUS));
        end
        // Small circles usually run to the end; large ones are cut short by a restart.
        steps = (pick < 75 && $urandom_range(0, 3) != 0) ? 1000 : $urandom_range(0, 6);
        send_item(OP_START, radius, COLOR_W'($urandom));
        while (circle_live && steps > 0) begin
            send_item(OP_ADVANCE, COORD_W'($urandom), COLOR_W'($urandom));
            steps--;
        end
        if (!circle_live && $urandom_range(0, 3) == 0) begin
            send_item(OP_ADVANCE, COORD_W'($urandom), COLOR_W'($urandom));
        end
    endtask

    task automatic test_random_circles(input logic [31:0] cx, input logic [31:0] cy,
                                       input bit burst, input int groups);
        int goal;
        wait_drained();
        set_center(cx, cy);
        flow_burst = burst;
        goal = groups_queued + groups;
        while (groups_queued < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(logic'($urandom_range(0, 1)), COORD_W'($urandom), COLOR_W'($urandom));
            end else begin
                draw_circle();
            end
        end
        flow_burst = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            ready_pick = pick_pause();
            m_tready   <= (ready_pick == 0);
            ready_hold <= (ready_pick > 0) ? ready_pick - 1 : 0;
        end
    end

    always @(posedge aclk) begin : check_pixels
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel transaction: pixel_x %0d, pixel_y %0d",
                       $signed(m_tdata[PIXEL_W-1:0]), $signed(m_tdata[2*PIXEL_W-1:PIXEL_W]));
                failures++;
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_tdata[PIXEL_W-1:0] !== want.x) begin
                    $error("pixel_x mismatch: expected %0d, got %0d",
                           $signed(want.x), $signed(m_tdata[PIXEL_W-1:0]));
                    failures++;
                end
                if (m_tdata[2*PIXEL_W-1:PIXEL_W] !== want.y) begin
                    $error("pixel_y mismatch: expected %0d, got %0d",
                           $signed(want.y), $signed(m_tdata[2*PIXEL_W-1:PIXEL_W]));
                    failures++;
                end
                if (m_tdata[2*PIXEL_W+COLOR_W-1:2*PIXEL_W] !== want.color) begin
                    $error("pixel_color mismatch: expected %h, got %h",
                           want.color, m_tdata[2*PIXEL_W+COLOR_W-1:2*PIXEL_W]);
                    failures++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_group mismatch: expected %0b, got %0b", want.last, m_tlast);
                    failures++;
                end
                if (m_tuser !== want.done) begin
                    $error("circle_done mismatch: expected %0b, got %0b", want.done, m_tuser);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d pixels still expected",
                     idle_cycles, expected_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_advance_without_circle();
        test_zero_radius();
        test_radius_one();
        test_center_extremes();
        test_random_circles($urandom, $urandom, 1'b0, 45);
        test_random_circles(32'h0000_0FFF, 32'h0000_0000, 1'b1, 45);
        test_random_circles(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 45);
        test_random_circles($urandom, $urandom, 1'b0, 45);
        wait_drained();
        $display("Sent %0d input transactions: %0d pixel groups, %0d circles ended.",
                 items_sent, groups_queued, circles_finished);
        $display("Checked %0d pixels over four center settings and both center extremes.",
                 pixels_checked);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
src/mcr_pkg.sv
src/mcr_step.sv
src/mcr_octant.sv
src/midpoint_circle_rasterizer.sv
tb/sv/tb.sv
